>>> design/wfot_pkg.sv
package wfot_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = DATA_WIDTH + 4;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int LANES = 4;
  localparam int ROW_WIDTH = 2;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [ROW_WIDTH-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_WIDTH-1:0] ROW_SECOND = 2'd1;
  localparam logic [ROW_WIDTH-1:0] ROW_THIRD = 2'd2;
  localparam logic [ROW_WIDTH-1:0] ROW_LAST = 2'd3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIAS_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NORM_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELU_ENABLE = 2'd2;

  // signed data range, sign-extended to product width
  localparam logic signed [PROD_WIDTH-1:0] SAT_MAX =
    {{(DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [PROD_WIDTH-1:0] SAT_MIN =
    {{(DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_BIAS,
    STEP_MEAN,
    STEP_MUL1,
    STEP_SH1,
    STEP_MUL2,
    STEP_SH2
  } step_t;

  typedef struct packed {
    step_t step;
    logic  bias_en;
    logic  norm_en;
    logic  relu_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] bias;
    logic signed [DATA_WIDTH-1:0] mean;
    logic signed [DATA_WIDTH-1:0] inverse_deviation;
    logic signed [DATA_WIDTH-1:0] scale;
    logic signed [DATA_WIDTH-1:0] shift;
  } chan_params_t;

  typedef logic [LANES-1:0][ACC_WIDTH-1:0] acc_vec_t;
  typedef logic [LANES-1:0][DATA_WIDTH-1:0] data_vec_t;

  function automatic logic [DATA_WIDTH-1:0] sat_wide(input logic signed [PROD_WIDTH-1:0] x);
    logic [DATA_WIDTH-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[DATA_WIDTH-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[DATA_WIDTH-1:0];
    end else begin
      r = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/wfot_accum.sv
module wfot_accum
  import wfot_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [ROW_WIDTH-1:0]         row,
  input  logic signed [DATA_WIDTH-1:0] e0,
  input  logic signed [DATA_WIDTH-1:0] e1,
  input  logic signed [DATA_WIDTH-1:0] e2,
  input  logic signed [DATA_WIDTH-1:0] e3,
  output acc_vec_t                     sums
);

  acc_vec_t                    sums_r;
  acc_vec_t                    sums_nxt;
  acc_vec_t                    base;
  logic signed [ACC_WIDTH-1:0] c0;
  logic signed [ACC_WIDTH-1:0] c1;

  always_comb begin
    c0 = ACC_WIDTH'(e0) + ACC_WIDTH'(e1) + ACC_WIDTH'(e2);
    c1 = ACC_WIDTH'(e1) - ACC_WIDTH'(e2) - ACC_WIDTH'(e3);
    base = (row == ROW_FIRST) ? '0 : sums_r;
    sums_nxt = base;
    // row weights: a0 = (1,1,1,0) feeds y0x, a1 = (0,1,-1,-1) feeds y1x
    unique case (row)
      ROW_FIRST: begin
        sums_nxt[0] = base[0] + c0;
        sums_nxt[1] = base[1] + c1;
      end
      ROW_SECOND: begin
        sums_nxt[0] = base[0] + c0;
        sums_nxt[1] = base[1] + c1;
        sums_nxt[2] = base[2] + c0;
        sums_nxt[3] = base[3] + c1;
      end
      ROW_THIRD: begin
        sums_nxt[0] = base[0] + c0;
        sums_nxt[1] = base[1] + c1;
        sums_nxt[2] = base[2] - c0;
        sums_nxt[3] = base[3] - c1;
      end
      ROW_LAST: begin
        sums_nxt[2] = base[2] - c0;
        sums_nxt[3] = base[3] - c1;
      end
      default: sums_nxt = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else if (en) begin
      sums_r <= sums_nxt;
    end
  end

  assign sums = sums_r;

endmodule

>>> design/wfot_lane.sv
module wfot_lane
  import wfot_pkg::*;
(
  input  logic                  clk,
  input  lane_ctrl_t            ctrl,
  input  logic [ACC_WIDTH-1:0]  sum,
  input  chan_params_t          params,
  output logic [DATA_WIDTH-1:0] result
);

  logic signed [DATA_WIDTH-1:0] v_r;
  logic signed [DATA_WIDTH-1:0] d_r;
  logic signed [DATA_WIDTH-1:0] p_r;
  logic signed [DATA_WIDTH-1:0] res_r;
  logic signed [PROD_WIDTH-1:0] prod_r;

  logic [DATA_WIDTH-1:0]        bias_term;
  logic [ACC_WIDTH:0]           biased;
  logic [DATA_WIDTH-1:0]        v_nxt;
  logic [DATA_WIDTH:0]          centered;
  logic [DATA_WIDTH-1:0]        d_nxt;
  logic signed [DATA_WIDTH-1:0] mul_a;
  logic signed [DATA_WIDTH-1:0] mul_b;
  logic signed [PROD_WIDTH-1:0] prod_nxt;
  logic signed [PROD_WIDTH-1:0] shifted;
  logic [DATA_WIDTH-1:0]        sh_nxt;
  logic [DATA_WIDTH:0]          offset;
  logic [DATA_WIDTH-1:0]        norm_out;
  logic [DATA_WIDTH-1:0]        final_v;
  logic [DATA_WIDTH-1:0]        res_nxt;

  always_comb begin
    bias_term = ctrl.bias_en ? params.bias : '0;
    biased = {sum[ACC_WIDTH-1], sum}
           + {{(ACC_WIDTH+1-DATA_WIDTH){bias_term[DATA_WIDTH-1]}}, bias_term};
    v_nxt = sat_wide({{(PROD_WIDTH-ACC_WIDTH-1){biased[ACC_WIDTH]}}, biased});

    centered = {v_r[DATA_WIDTH-1], v_r} - {params.mean[DATA_WIDTH-1], params.mean};
    d_nxt = sat_wide({{(PROD_WIDTH-DATA_WIDTH-1){centered[DATA_WIDTH]}}, centered});

    // one multiplier per lane, used for both products
    mul_a = (ctrl.step == STEP_MUL1) ? d_r : p_r;
    mul_b = (ctrl.step == STEP_MUL1) ? params.inverse_deviation : params.scale;
    prod_nxt = mul_a * mul_b;

    shifted = prod_r >>> FRAC_BITS;
    sh_nxt = sat_wide(shifted);

    offset = {sh_nxt[DATA_WIDTH-1], sh_nxt} + {params.shift[DATA_WIDTH-1], params.shift};
    norm_out = sat_wide({{(PROD_WIDTH-DATA_WIDTH-1){offset[DATA_WIDTH]}}, offset});

    final_v = ctrl.norm_en ? norm_out : d_r;
    res_nxt = (ctrl.relu_en && final_v[DATA_WIDTH-1]) ? '0 : final_v;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.step)
      STEP_BIAS: v_r <= v_nxt;
      STEP_MEAN: d_r <= ctrl.norm_en ? d_nxt : v_r;
      STEP_MUL1: prod_r <= prod_nxt;
      STEP_SH1:  p_r <= sh_nxt;
      STEP_MUL2: prod_r <= prod_nxt;
      STEP_SH2:  res_r <= res_nxt;
      default:   ;
    endcase
  end

  assign result = res_r;

endmodule

>>> design/wfot_merge.sv
module wfot_merge
  import wfot_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  data_vec_t                    results,
  input  logic                         out_ready,
  output logic                         free,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out00,
  output logic signed [DATA_WIDTH-1:0] out01,
  output logic signed [DATA_WIDTH-1:0] out10,
  output logic signed [DATA_WIDTH-1:0] out11
);

  logic      valid_r;
  data_vec_t tile_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tile_r <= results;
    end
  end

  assign out_valid = valid_r;
  assign out00 = tile_r[0];
  assign out01 = tile_r[1];
  assign out10 = tile_r[2];
  assign out11 = tile_r[3];

endmodule

>>> design/winograd_f2x3_output_transform.sv
// Winograd F(2x2,3x3) output transform. Rows 0..2 of a 4x4 product tile
// are taken one beat per cycle while idle and folded into four 36-bit sums.
// The row 3 beat closes the tile: four lanes, one per output pixel, then
// run bias, batch norm and ReLU through six steps on one multiplier each,
// so after a row 3 beat the input stalls through the six lane steps and the
// hand-off to the output register, which waits while it is full. The
// finished 2x2 tile waits in that register, so the next tile's rows are
// taken while it is pending. Configuration writes are taken every cycle.
module winograd_f2x3_output_transform
  import wfot_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic                         cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ROW_WIDTH-1:0]         in_row_index,
  input  logic signed [DATA_WIDTH-1:0] in_elem0,
  input  logic signed [DATA_WIDTH-1:0] in_elem1,
  input  logic signed [DATA_WIDTH-1:0] in_elem2,
  input  logic signed [DATA_WIDTH-1:0] in_elem3,
  input  logic signed [DATA_WIDTH-1:0] in_bias,
  input  logic signed [DATA_WIDTH-1:0] in_mean,
  input  logic signed [DATA_WIDTH-1:0] in_inverse_deviation,
  input  logic signed [DATA_WIDTH-1:0] in_scale,
  input  logic signed [DATA_WIDTH-1:0] in_shift,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out00,
  output logic signed [DATA_WIDTH-1:0] out01,
  output logic signed [DATA_WIDTH-1:0] out10,
  output logic signed [DATA_WIDTH-1:0] out11
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_MEAN,
    S_MUL1,
    S_SH1,
    S_MUL2,
    S_SH2,
    S_HOLD
  } state_t;

  state_t       state_r;
  state_t       state_nxt;
  logic         bias_en_r;
  logic         norm_en_r;
  logic         relu_en_r;
  chan_params_t params_r;
  lane_ctrl_t   lane_ctrl;
  acc_vec_t     sums;
  data_vec_t    lane_res;
  logic         in_fire;
  logic         out_free;
  logic         out_load;

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_load = (state_r == S_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_en_r <= 1'b0;
      norm_en_r <= 1'b0;
      relu_en_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BIAS_ENABLE: bias_en_r <= cfg_data;
        REG_NORM_ENABLE: norm_en_r <= cfg_data;
        REG_RELU_ENABLE: relu_en_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && in_row_index == ROW_LAST) state_nxt = S_BIAS;
      S_BIAS:  state_nxt = S_MEAN;
      S_MEAN:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_SH1;
      S_SH1:   state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_SH2;
      S_SH2:   state_nxt = S_HOLD;
      S_HOLD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // channel parameters ride with the row 3 beat
  always_ff @(posedge clk) begin
    if (in_fire && in_row_index == ROW_LAST) begin
      params_r.bias <= in_bias;
      params_r.mean <= in_mean;
      params_r.inverse_deviation <= in_inverse_deviation;
      params_r.scale <= in_scale;
      params_r.shift <= in_shift;
    end
  end

  always_comb begin
    lane_ctrl.bias_en = bias_en_r;
    lane_ctrl.norm_en = norm_en_r;
    lane_ctrl.relu_en = relu_en_r;
    unique case (state_r)
      S_BIAS:  lane_ctrl.step = STEP_BIAS;
      S_MEAN:  lane_ctrl.step = STEP_MEAN;
      S_MUL1:  lane_ctrl.step = STEP_MUL1;
      S_SH1:   lane_ctrl.step = STEP_SH1;
      S_MUL2:  lane_ctrl.step = STEP_MUL2;
      S_SH2:   lane_ctrl.step = STEP_SH2;
      default: lane_ctrl.step = STEP_NONE;
    endcase
  end

  wfot_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_fire),
    .row   (in_row_index),
    .e0    (in_elem0),
    .e1    (in_elem1),
    .e2    (in_elem2),
    .e3    (in_elem3),
    .sums  (sums)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    wfot_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .sum    (sums[g]),
      .params (params_r),
      .result (lane_res[g])
    );
  end

  wfot_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .results   (lane_res),
    .out_ready (out_ready),
    .free      (out_free),
    .out_valid (out_valid),
    .out00     (out00),
    .out01     (out01),
    .out10     (out10),
    .out11     (out11)
  );

endmodule
